// ===== sv/sds_pkg.sv =====
`default_nettype none

package sds_pkg;

   typedef struct packed {
      logic valid;
      logic negate;
      logic num_zero;
      logic den_zero;
   } sds_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/signed_divide_saturating.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_numerator, req_denominator
// rsp       out        rsp_valid/rsp_stall   rsp_quotient, rsp_saturated
//
// One transfer is accepted every cycle while req_stall is low; the restoring divider
// resolves one quotient bit per registered stage, between input and output registers.
// Reset is synchronous and clears all valid bits; no other initialization is needed.
// A stalled result parks in a one-entry skid register, and req_stall follows its fill state.
`default_nettype none

module signed_divide_saturating #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [DATA_WIDTH-1:0] req_numerator,
   input  wire logic signed [DATA_WIDTH-1:0] req_denominator,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0]      rsp_quotient,
   output logic                              rsp_saturated
);

   localparam logic [DATA_WIDTH-1:0] PosMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic advance;
   logic take;
   logic pipe_done;
   logic out_free;

   logic [DATA_WIDTH-1:0] num_mag;
   logic [DATA_WIDTH-1:0] den_mag;
   sds_pkg::sds_ctrl_type ctrl_in;

   sds_pkg::sds_ctrl_type ctrl_pipe [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] rem_pipe  [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] work_pipe [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] den_pipe  [0:DATA_WIDTH];

   sds_pkg::sds_ctrl_type ctrl_ff;
   logic [DATA_WIDTH-1:0] num_ff;
   logic [DATA_WIDTH-1:0] den_ff;

   logic [DATA_WIDTH-1:0] fin_quotient;
   logic                  fin_saturated;

   logic                  out_valid_ff;
   logic [DATA_WIDTH-1:0] out_quotient_ff;
   logic                  out_saturated_ff;
   logic                  skid_valid_ff;
   logic [DATA_WIDTH-1:0] skid_quotient_ff;
   logic                  skid_saturated_ff;

   assign advance = ~skid_valid_ff;
   assign take    = out_valid_ff & ~rsp_stall;
   assign out_free = ~out_valid_ff | take;

   always_comb begin
      num_mag          = req_numerator[DATA_WIDTH-1] ? -req_numerator : req_numerator;
      den_mag          = req_denominator[DATA_WIDTH-1] ? -req_denominator : req_denominator;
      ctrl_in.valid    = req_valid;
      ctrl_in.negate   = req_numerator[DATA_WIDTH-1] ^ req_denominator[DATA_WIDTH-1];
      ctrl_in.num_zero = (req_numerator == '0);
      ctrl_in.den_zero = (req_denominator == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= num_mag;
         den_ff <= den_mag;
      end
   end

   assign ctrl_pipe[0] = ctrl_ff;
   assign rem_pipe[0]  = '0;
   assign work_pipe[0] = num_ff;
   assign den_pipe[0]  = den_ff;

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_stage
      sds_div_stage #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctrl_in (ctrl_pipe[i]),
         .rem_in  (rem_pipe[i]),
         .work_in (work_pipe[i]),
         .den_in  (den_pipe[i]),
         .ctrl_out(ctrl_pipe[i+1]),
         .rem_out (rem_pipe[i+1]),
         .work_out(work_pipe[i+1]),
         .den_out (den_pipe[i+1])
      );
   end

   always_comb begin
      fin_quotient  = work_pipe[DATA_WIDTH];
      fin_saturated = 1'b0;
      if (ctrl_pipe[DATA_WIDTH].num_zero) begin
         fin_quotient = '0;
      end else if (ctrl_pipe[DATA_WIDTH].den_zero) begin
         fin_quotient  = PosMax;
         fin_saturated = 1'b1;
      end else if (ctrl_pipe[DATA_WIDTH].negate) begin
         fin_quotient = -work_pipe[DATA_WIDTH];
      end else if (work_pipe[DATA_WIDTH] > PosMax) begin
         fin_quotient  = PosMax;
         fin_saturated = 1'b1;
      end
   end

   assign pipe_done = ctrl_pipe[DATA_WIDTH].valid & advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_free) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (pipe_done) begin
         out_valid_ff <= 1'b1;
         if (!out_free) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_free) begin
            out_quotient_ff  <= skid_quotient_ff;
            out_saturated_ff <= skid_saturated_ff;
         end
      end else if (pipe_done) begin
         if (out_free) begin
            out_quotient_ff  <= fin_quotient;
            out_saturated_ff <= fin_saturated;
         end else begin
            skid_quotient_ff  <= fin_quotient;
            skid_saturated_ff <= fin_saturated;
         end
      end
   end

   assign req_stall     = skid_valid_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_quotient  = out_quotient_ff;
   assign rsp_saturated = out_saturated_ff;

endmodule

`default_nettype wire

// ===== sv/sds_div_stage.sv =====
`default_nettype none

module sds_div_stage #(
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire sds_pkg::sds_ctrl_type        ctrl_in,
   input  wire logic [DATA_WIDTH-1:0]        rem_in,
   input  wire logic [DATA_WIDTH-1:0]        work_in,
   input  wire logic [DATA_WIDTH-1:0]        den_in,
   output sds_pkg::sds_ctrl_type             ctrl_out,
   output logic [DATA_WIDTH-1:0]             rem_out,
   output logic [DATA_WIDTH-1:0]             work_out,
   output logic [DATA_WIDTH-1:0]             den_out
);

   logic [DATA_WIDTH:0]   shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;
   logic [DATA_WIDTH-1:0] rem_in_next;
   logic [DATA_WIDTH-1:0] work_in_next;

   sds_pkg::sds_ctrl_type ctrl_ff;
   logic [DATA_WIDTH-1:0] rem_ff;
   logic [DATA_WIDTH-1:0] work_ff;
   logic [DATA_WIDTH-1:0] den_ff;

   always_comb begin
      shifted      = {rem_in, work_in[DATA_WIDTH-1]};
      diff         = shifted - {1'b0, den_in};
      fits         = ~diff[DATA_WIDTH];
      rem_in_next  = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
      work_in_next = {work_in[DATA_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in_next;
         work_ff <= work_in_next;
         den_ff  <= den_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign rem_out  = rem_ff;
   assign work_out = work_ff;
   assign den_out  = den_ff;

endmodule

`default_nettype wire

// ===== sv/sds_checker.sv =====
`default_nettype none

module sds_checker #(
   parameter int DATA_WIDTH = 32
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic [DATA_WIDTH-1:0] req_numerator,
   input wire logic [DATA_WIDTH-1:0] req_denominator,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire logic [DATA_WIDTH-1:0] rsp_quotient,
   input wire logic                  rsp_saturated
);

   localparam logic [DATA_WIDTH-1:0] PosMax = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   // A saturated result always carries the largest positive value.
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_quotient == PosMax)
      else $error("saturated result without largest positive quotient");

   // The input side only stalls while a result is waiting at the output.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty output");

   // A stalled request stays offered with the same operands.
   a_req_stable: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_numerator)
                                 && $stable(req_denominator))
      else $error("request changed while stalled");

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_quotient) && $stable(rsp_saturated))
      else $error("result payload changed while stalled");

endmodule

bind signed_divide_saturating sds_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sds_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int DW = 32;
   localparam int RANDOM_PAIRS = 1500;
   localparam int CALM_TAIL = 150;
   localparam int HOLD_AT = 400;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = DW + 20;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic signed [DW-1:0] INT_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [DW-1:0] INT_MAX = ~INT_MIN;

   typedef struct packed {
      logic signed [DW-1:0] numerator;
      logic signed [DW-1:0] denominator;
   } operand_pair_type;

   typedef struct packed {
      logic signed [DW-1:0] quotient;
      logic                 saturated;
   } quotient_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [DW-1:0] req_numerator = '0;
   logic signed [DW-1:0] req_denominator = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [DW-1:0] rsp_quotient;
   logic                 rsp_saturated;

   operand_pair_type pending_pairs[$];
   quotient_type     expected_quotients[$];
   operand_pair_type next_pair;
   quotient_type     want;

   int  total_pairs = 0;
   int  directed_pairs = 0;
   int  sent_pairs = 0;
   int  checked_quotients = 0;
   int  saturated_quotients = 0;
   int  input_stall_cycles = 0;
   int  mismatches = 0;
   int  cycles = 0;
   logic req_fired = 1'b0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  req_idle_pct = 20;
   int  rsp_idle_pct = 20;
   int  hold_left = 0;
   logic hold_done = 1'b0;
   logic calm;

   signed_divide_saturating #(.DATA_WIDTH(DW)) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_numerator   (req_numerator),
      .req_denominator (req_denominator),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_quotient    (rsp_quotient),
      .rsp_saturated   (rsp_saturated)
   );

   always #5 clock = ~clock;

   assign calm = sent_pairs >= total_pairs - CALM_TAIL;

   function automatic quotient_type divide_truncated(input logic signed [DW-1:0] n,
                                                     input logic signed [DW-1:0] d);
      logic [DW-1:0] nmag;
      logic [DW-1:0] dmag;
      logic [DW-1:0] qmag;
      quotient_type  r;
      nmag = n;
      dmag = d;
      if (n[DW-1]) nmag = ~nmag + 1'b1;
      if (d[DW-1]) dmag = ~dmag + 1'b1;
      r.quotient = '0;
      r.saturated = 1'b0;
      if (nmag == '0) begin
         r.quotient = '0;
      end else if (dmag == '0) begin
         r.quotient = INT_MAX;
         r.saturated = 1'b1;
      end else begin
         qmag = nmag / dmag;
         if (n[DW-1] != d[DW-1]) begin
            r.quotient = ~qmag + 1'b1;
         end else if (qmag[DW-1]) begin
            r.quotient = INT_MAX;
            r.saturated = 1'b1;
         end else begin
            r.quotient = qmag;
         end
      end
      return r;
   endfunction

   function automatic logic signed [DW-1:0] random_operand();
      int kind;
      logic signed [DW-1:0] v;
      kind = $urandom_range(99);
      if (kind < 45) begin
         v = $urandom();
      end else if (kind < 65) begin
         v = $urandom_range(20);
         if ($urandom_range(1)) v = -v;
      end else if (kind < 80) begin
         case ($urandom_range(4))
            0: v = INT_MIN;
            1: v = INT_MAX;
            2: v = '0;
            3: v = 1;
            default: v = -1;
         endcase
      end else begin
         v = $urandom();
         v = v >>> $urandom_range(1, DW - 1);
      end
      return v;
   endfunction

   task automatic push_pair(input logic signed [DW-1:0] n, input logic signed [DW-1:0] d);
      operand_pair_type p;
      p.numerator = n;
      p.denominator = d;
      pending_pairs.push_back(p);
      total_pairs++;
   endtask

   task automatic report_mismatch(input string what, input logic signed [DW-1:0] got,
                                  input logic signed [DW-1:0] exp);
      $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, exp);
      mismatches++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      req_fired <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_quotients.push_back(divide_truncated(req_numerator, req_denominator));
         sent_pairs <= sent_pairs + 1;
      end
      if (!reset && req_valid && req_stall) input_stall_cycles <= input_stall_cycles + 1;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if ($urandom_range(63) == 0) req_idle_pct <= 15 * $urandom_range(3);
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (req_valid && !calm && $urandom_range(99) < req_idle_pct) begin
            req_valid <= 1'b0;
            req_gap <= $urandom_range(6);
         end else if (pending_pairs.size() > 0) begin
            next_pair = pending_pairs.pop_front();
            req_valid <= 1'b1;
            req_numerator <= next_pair.numerator;
            req_denominator <= next_pair.denominator;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if ($urandom_range(63) == 0) rsp_idle_pct <= 15 * $urandom_range(3);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && sent_pairs >= HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
      end else if (rsp_gap > 0) begin
         rsp_stall <= 1'b1;
         rsp_gap <= rsp_gap - 1;
      end else if (!calm && $urandom_range(99) < rsp_idle_pct) begin
         rsp_stall <= 1'b1;
         rsp_gap <= $urandom_range(6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_quotients.size() == 0) begin
            report_mismatch("unexpected transfer, quotient", rsp_quotient, '0);
         end else begin
            want = expected_quotients.pop_front();
            if (rsp_quotient !== want.quotient)
               report_mismatch("quotient", rsp_quotient, want.quotient);
            if (rsp_saturated !== want.saturated)
               report_mismatch("saturated", DW'(rsp_saturated), DW'(want.saturated));
            checked_quotients <= checked_quotients + 1;
            if (want.saturated) saturated_quotients <= saturated_quotients + 1;
         end
      end
   end

   initial begin
      push_pair(0, 0);
      push_pair(0, 5);
      push_pair(0, INT_MIN);
      push_pair(5, 0);
      push_pair(-5, 0);
      push_pair(INT_MIN, 0);
      push_pair(INT_MAX, 0);
      push_pair(INT_MIN, -1);
      push_pair(INT_MIN, 1);
      push_pair(INT_MAX, -1);
      push_pair(INT_MAX, 1);
      push_pair(INT_MIN, INT_MIN);
      push_pair(5, INT_MIN);
      push_pair(INT_MAX, INT_MIN);
      push_pair(-1, INT_MIN);
      push_pair(7, 2);
      push_pair(-7, 2);
      push_pair(7, -2);
      push_pair(-7, -2);
      push_pair(INT_MAX, INT_MAX);
      push_pair(INT_MIN, INT_MAX);
      push_pair(-1, -1);
      push_pair(1, -1);
      push_pair(3, 7);
      directed_pairs = total_pairs;
      repeat (RANDOM_PAIRS) push_pair(random_operand(), random_operand());

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() != 0 || req_valid || expected_quotients.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_quotients.size() != 0) begin
         $display("%0d expected quotients never arrived", expected_quotients.size());
         mismatches++;
      end

      $display("Sent %0d operand pairs (%0d directed); checked %0d quotients, %0d saturated.",
               sent_pairs, directed_pairs, checked_quotients, saturated_quotients);
      $display("Receiver held off for %0d cycles once; input stalled on %0d cycles.",
               HOLD_CYCLES, input_stall_cycles);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
